>>> src/tfcm_pkg.sv
// Shared types, widths and constants of the temperature false-color mapper.
// Used by tfcm_div and temperature_false_color_mapper_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tfcm_pkg;

   // Fraction bits of the hue word
   localparam int HUE_FRACTION_BITS = 8;

   localparam int TEMP_W   = 16;
   localparam int HUE_W    = 9;
   localparam int LVL_W    = 9;
   localparam int RGB_W    = 8;
   localparam int FRAC_W   = 8;
   localparam int LVL_FULL = 1 << FRAC_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Linear map and divider
   localparam int DT_W     = TEMP_W + 1;
   localparam int DH_W     = HUE_W + 1;
   localparam int PROD_W   = DT_W + DH_W - 1;
   localparam int MAG_W    = PROD_W - 1;
   localparam int NUM_W    = MAG_W + HUE_FRACTION_BITS;
   localparam int DEN_W    = TEMP_W;
   localparam int Q_W      = HUE_W + HUE_FRACTION_BITS + 1;
   localparam int REM_W    = DEN_W;
   localparam int DIV_BPS  = 3;
   localparam int DIV_STAGES = (Q_W + DIV_BPS - 1) / DIV_BPS;

   // Hue word and sextant split
   localparam int HUEV_W = HUE_W + HUE_FRACTION_BITS;
   localparam int HUES_W = Q_W + 2;
   localparam int WRAP   = 360 << HUE_FRACTION_BITS;
   localparam int SPAN   = 60 << HUE_FRACTION_BITS;
   localparam int SPAN_W = $clog2(SPAN);
   localparam int FX_W   = SPAN_W + FRAC_W;
   localparam int SF_W   = LVL_W + FRAC_W;
   localparam int MIX_W  = 2 * FRAC_W + 1;
   localparam int MV_W   = LVL_W + MIX_W;

   // Register reset values
   localparam logic [TEMP_W-1:0] TEMP_LOW_RST   = TEMP_W'(320);
   localparam logic [TEMP_W-1:0] TEMP_HIGH_RST  = TEMP_W'(3200);
   localparam logic [HUE_W-1:0]  HUE_LOW_RST    = HUE_W'(180);
   localparam logic [HUE_W-1:0]  HUE_HIGH_RST   = HUE_W'(360);
   localparam logic [LVL_W-1:0]  SATURATION_RST = LVL_W'(256);
   localparam logic [LVL_W-1:0]  BRIGHTNESS_RST = LVL_W'(256);

   typedef enum logic [2:0] {
      CSR_TEMP_LOW   = 3'd0,
      CSR_TEMP_HIGH  = 3'd1,
      CSR_HUE_LOW    = 3'd2,
      CSR_HUE_HIGH   = 3'd3,
      CSR_SATURATION = 3'd4,
      CSR_BRIGHTNESS = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      SEXT_R_Y = 3'd0,
      SEXT_Y_G = 3'd1,
      SEXT_G_C = 3'd2,
      SEXT_C_B = 3'd3,
      SEXT_B_M = 3'd4,
      SEXT_M_R = 3'd5
   } sextant_type;

   // One slot of the restoring divider
   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [REM_W-1:0] rem;
      logic [Q_W-1:0]   low;
      logic [Q_W-1:0]   quo;
   } div_stage_type;

endpackage

`default_nettype wire

>>> src/tfcm_div.sv
// Pipelined restoring divider, a few quotient bits per register stage.
// Depends on tfcm_pkg for widths and the div_stage_type slot.
`timescale 1ns / 1ps
`default_nettype none

module tfcm_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  tfcm_pkg::div_stage_type    in_data,
   input  wire  [tfcm_pkg::DEN_W-1:0] den,
   output logic                       out_valid,
   input  wire                        out_ready,
   output tfcm_pkg::div_stage_type    out_data
);

   logic [tfcm_pkg::DIV_STAGES-1:0] valid_ff;
   logic [tfcm_pkg::DIV_STAGES:0]   ready;
   tfcm_pkg::div_stage_type         stage_ff [tfcm_pkg::DIV_STAGES];
   tfcm_pkg::div_stage_type         stage_in [tfcm_pkg::DIV_STAGES];

   // Shift in one numerator bit, subtract when it fits
   function automatic tfcm_pkg::div_stage_type div_step(
      input tfcm_pkg::div_stage_type cur,
      input logic [tfcm_pkg::DEN_W-1:0] d
   );
      logic [tfcm_pkg::REM_W:0] cand;
      tfcm_pkg::div_stage_type  nxt;
      nxt  = cur;
      cand = {cur.rem, cur.low[tfcm_pkg::Q_W-1]};
      nxt.low = {cur.low[tfcm_pkg::Q_W-2:0], 1'b0};
      if (cand >= {1'b0, d}) begin
         nxt.rem = tfcm_pkg::REM_W'(cand - {1'b0, d});
         nxt.quo = {cur.quo[tfcm_pkg::Q_W-2:0], 1'b1};
      end else begin
         nxt.rem = cand[tfcm_pkg::REM_W-1:0];
         nxt.quo = {cur.quo[tfcm_pkg::Q_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   assign ready[tfcm_pkg::DIV_STAGES] = out_ready;
   assign in_ready  = ready[0];
   assign out_valid = valid_ff[tfcm_pkg::DIV_STAGES-1];
   assign out_data  = stage_ff[tfcm_pkg::DIV_STAGES-1];

   for (genvar g = 0; g < tfcm_pkg::DIV_STAGES; g++) begin : g_stage
      tfcm_pkg::div_stage_type nxt;
      logic                    vin;

      if (g == 0) begin : g_first
         assign stage_in[g] = in_data;
         assign vin         = in_valid;
      end else begin : g_rest
         assign stage_in[g] = stage_ff[g-1];
         assign vin         = valid_ff[g-1];
      end

      assign ready[g] = !valid_ff[g] || ready[g+1];

      always_comb begin
         nxt = stage_in[g];
         for (int j = 0; j < tfcm_pkg::DIV_BPS; j++) begin
            if (g * tfcm_pkg::DIV_BPS + j < tfcm_pkg::Q_W) begin
               nxt = div_step(nxt, den);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (ready[g]) begin
            valid_ff[g] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[g]) begin
            stage_ff[g] <= nxt;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/temperature_false_color_mapper_core.sv
// Top level of the temperature false-color mapper: CSRs, map, HSV to RGB pipeline.
// Depends on tfcm_pkg and instantiates tfcm_div for the linear-map division.
//
//   channel  direction  handshake                     payload
//   req      in         req_valid / req_stall         req_temperature (s16)
//   rsp      out        rsp_valid / rsp_stall         rsp_red, rsp_green, rsp_blue (u8)
//   csr      in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One sample per cycle sustained while rsp_stall is low; a transfer on req passes
// through three map stages, six divider stages and five color stages to rsp.
// Divider depth is set by the 18-bit quotient of the linear map, three bits per stage.
// Reset is synchronous and clears every valid bit and loads the CSR defaults.
// Each stage holds while the one after it is full and held; rsp_stall only freezes
// full stages, so bubbles close up and req keeps taking transfers until all fill.
`timescale 1ns / 1ps
`default_nettype none

module temperature_false_color_mapper_core (
   input  wire                             clock,
   input  wire                             reset,
   // sample input
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [tfcm_pkg::TEMP_W-1:0]     req_temperature,
   // color output
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [tfcm_pkg::RGB_W-1:0]      rsp_red,
   output logic [tfcm_pkg::RGB_W-1:0]      rsp_green,
   output logic [tfcm_pkg::RGB_W-1:0]      rsp_blue,
   // configuration
   input  wire                             psel,
   input  wire                             penable,
   input  wire                             pwrite,
   input  wire  [tfcm_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire  [tfcm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tfcm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   // ------------------------------------------------------------------
   // CSRs
   // ------------------------------------------------------------------
   logic [tfcm_pkg::TEMP_W-1:0] temp_low_ff;
   logic [tfcm_pkg::TEMP_W-1:0] temp_high_ff;
   logic [tfcm_pkg::HUE_W-1:0]  hue_low_ff;
   logic [tfcm_pkg::HUE_W-1:0]  hue_high_ff;
   logic [tfcm_pkg::LVL_W-1:0]  saturation_ff;
   logic [tfcm_pkg::LVL_W-1:0]  brightness_ff;
   logic [2:0]                  csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[tfcm_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_low_ff   <= tfcm_pkg::TEMP_LOW_RST;
         temp_high_ff  <= tfcm_pkg::TEMP_HIGH_RST;
         hue_low_ff    <= tfcm_pkg::HUE_LOW_RST;
         hue_high_ff   <= tfcm_pkg::HUE_HIGH_RST;
         saturation_ff <= tfcm_pkg::SATURATION_RST;
         brightness_ff <= tfcm_pkg::BRIGHTNESS_RST;
      end else if (psel && penable && pwrite) begin
         // indexes past the list drop the write
         unique case (csr_index)
            tfcm_pkg::CSR_TEMP_LOW:   temp_low_ff   <= pwdata[tfcm_pkg::TEMP_W-1:0];
            tfcm_pkg::CSR_TEMP_HIGH:  temp_high_ff  <= pwdata[tfcm_pkg::TEMP_W-1:0];
            tfcm_pkg::CSR_HUE_LOW:    hue_low_ff    <= pwdata[tfcm_pkg::HUE_W-1:0];
            tfcm_pkg::CSR_HUE_HIGH:   hue_high_ff   <= pwdata[tfcm_pkg::HUE_W-1:0];
            tfcm_pkg::CSR_SATURATION: saturation_ff <= pwdata[tfcm_pkg::LVL_W-1:0];
            tfcm_pkg::CSR_BRIGHTNESS: brightness_ff <= pwdata[tfcm_pkg::LVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tfcm_pkg::CSR_TEMP_LOW:   prdata = tfcm_pkg::CSR_DATA_W'(temp_low_ff);
         tfcm_pkg::CSR_TEMP_HIGH:  prdata = tfcm_pkg::CSR_DATA_W'(temp_high_ff);
         tfcm_pkg::CSR_HUE_LOW:    prdata = tfcm_pkg::CSR_DATA_W'(hue_low_ff);
         tfcm_pkg::CSR_HUE_HIGH:   prdata = tfcm_pkg::CSR_DATA_W'(hue_high_ff);
         tfcm_pkg::CSR_SATURATION: prdata = tfcm_pkg::CSR_DATA_W'(saturation_ff);
         tfcm_pkg::CSR_BRIGHTNESS: prdata = tfcm_pkg::CSR_DATA_W'(brightness_ff);
         default:                  prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Values derived from the CSRs. Configuration only changes while the pipeline
   // is empty: the user must keep to this, the block does not enforce it. So these feed the stages straight.
   // ------------------------------------------------------------------
   logic signed [tfcm_pkg::DT_W-1:0] den_s;
   logic                             den_neg;
   logic [tfcm_pkg::DT_W-1:0]        den_abs;
   logic [tfcm_pkg::DEN_W-1:0]       den_mag;
   logic                             bounds_equal;
   logic signed [tfcm_pkg::DH_W-1:0] hue_diff;
   logic [tfcm_pkg::HUE_W-1:0]       hue_lo;
   logic [tfcm_pkg::HUE_W-1:0]       hue_hi;
   logic [tfcm_pkg::LVL_W-1:0]       sat_eff;
   logic [tfcm_pkg::LVL_W-1:0]       val_eff;

   assign den_s   = $signed({temp_high_ff[tfcm_pkg::TEMP_W-1], temp_high_ff})
                  - $signed({temp_low_ff[tfcm_pkg::TEMP_W-1], temp_low_ff});
   assign den_neg = den_s[tfcm_pkg::DT_W-1];
   assign den_abs = den_neg ? tfcm_pkg::DT_W'(-den_s) : tfcm_pkg::DT_W'(den_s);
   assign den_mag = den_abs[tfcm_pkg::DEN_W-1:0];
   assign bounds_equal = (temp_low_ff == temp_high_ff);

   assign hue_diff = $signed({1'b0, hue_high_ff}) - $signed({1'b0, hue_low_ff});
   assign hue_lo   = (hue_low_ff < hue_high_ff) ? hue_low_ff : hue_high_ff;
   assign hue_hi   = (hue_low_ff < hue_high_ff) ? hue_high_ff : hue_low_ff;

   // saturate both levels to full scale
   assign sat_eff = (saturation_ff > tfcm_pkg::LVL_W'(tfcm_pkg::LVL_FULL))
                  ? tfcm_pkg::LVL_W'(tfcm_pkg::LVL_FULL) : saturation_ff;
   assign val_eff = (brightness_ff > tfcm_pkg::LVL_W'(tfcm_pkg::LVL_FULL))
                  ? tfcm_pkg::LVL_W'(tfcm_pkg::LVL_FULL) : brightness_ff;

   // ------------------------------------------------------------------
   // Pipeline handshake: each stage advances when empty or when the next
   // one advances.
   // ------------------------------------------------------------------
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s4_valid_ff, s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic s0_ready, s1_ready, s2_ready, s3_ready;
   logic s4_ready, s5_ready, s6_ready, s7_ready;
   logic div_in_ready;
   logic div_out_valid;

   assign s7_ready = !s7_valid_ff || !rsp_stall;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || div_in_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s0_ready = !s0_valid_ff || s1_ready;

   assign req_stall = !s0_ready;
   assign rsp_valid = s7_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) s0_valid_ff <= req_valid;
         if (s1_ready) s1_valid_ff <= s0_valid_ff;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= div_out_valid;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
         if (s5_ready) s5_valid_ff <= s4_valid_ff;
         if (s6_ready) s6_valid_ff <= s5_valid_ff;
         if (s7_ready) s7_valid_ff <= s6_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // S0: capture the sample
   // ------------------------------------------------------------------
   logic [tfcm_pkg::TEMP_W-1:0] s0_temp_ff;

   always_ff @(posedge clock) begin
      if (s0_ready) s0_temp_ff <= req_temperature;
   end

   // ------------------------------------------------------------------
   // S1: (t - temp_low) * (hue_high - hue_low)
   // ------------------------------------------------------------------
   logic signed [tfcm_pkg::DT_W-1:0]   s1_dt;
   logic signed [tfcm_pkg::PROD_W-1:0] s1_dt_ext;
   logic signed [tfcm_pkg::PROD_W-1:0] s1_dh_ext;
   logic signed [tfcm_pkg::PROD_W-1:0] s1_prod_in;
   logic signed [tfcm_pkg::PROD_W-1:0] s1_prod_ff;

   assign s1_dt = $signed({s0_temp_ff[tfcm_pkg::TEMP_W-1], s0_temp_ff})
                - $signed({temp_low_ff[tfcm_pkg::TEMP_W-1], temp_low_ff});
   assign s1_dt_ext = $signed({{(tfcm_pkg::PROD_W - tfcm_pkg::DT_W){s1_dt[tfcm_pkg::DT_W-1]}},
                               s1_dt});
   assign s1_dh_ext = $signed({{(tfcm_pkg::PROD_W - tfcm_pkg::DH_W){hue_diff[tfcm_pkg::DH_W-1]}},
                               hue_diff});
   assign s1_prod_in = s1_dt_ext * s1_dh_ext;

   always_ff @(posedge clock) begin
      if (s1_ready) s1_prod_ff <= s1_prod_in;
   end

   // ------------------------------------------------------------------
   // S2: sign and magnitude of the scaled numerator, quotient overflow
   // ------------------------------------------------------------------
   logic                             s2_prod_neg;
   logic [tfcm_pkg::PROD_W-1:0]      s2_prod_abs;
   logic [tfcm_pkg::NUM_W-1:0]       s2_num;
   tfcm_pkg::div_stage_type          s2_div_in;
   tfcm_pkg::div_stage_type          s2_div_ff;
   tfcm_pkg::div_stage_type          div_out;

   assign s2_prod_neg = s1_prod_ff[tfcm_pkg::PROD_W-1];
   assign s2_prod_abs = s2_prod_neg ? tfcm_pkg::PROD_W'(-s1_prod_ff)
                                    : tfcm_pkg::PROD_W'(s1_prod_ff);
   assign s2_num = {s2_prod_abs[tfcm_pkg::MAG_W-1:0], {tfcm_pkg::HUE_FRACTION_BITS{1'b0}}};

   always_comb begin
      s2_div_in.neg = s2_prod_neg ^ den_neg;
      s2_div_in.rem = tfcm_pkg::REM_W'(s2_num[tfcm_pkg::NUM_W-1:tfcm_pkg::Q_W]);
      s2_div_in.low = s2_num[tfcm_pkg::Q_W-1:0];
      s2_div_in.quo = '0;
      // quotient too large for the hue range: saturate, the clamp settles it
      s2_div_in.ovf = (s2_div_in.rem >= den_mag);
   end

   always_ff @(posedge clock) begin
      if (s2_ready) s2_div_ff <= s2_div_in;
   end

   tfcm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (div_in_ready),
      .in_data   (s2_div_ff),
      .den       (den_mag),
      .out_valid (div_out_valid),
      .out_ready (s3_ready),
      .out_data  (div_out)
   );

   // ------------------------------------------------------------------
   // S3: signed quotient plus hue_low, clamp, equal bounds, wrap at 360
   // ------------------------------------------------------------------
   logic [tfcm_pkg::Q_W-1:0]           s3_qmag;
   logic signed [tfcm_pkg::HUES_W-1:0] s3_qs;
   logic signed [tfcm_pkg::HUES_W-1:0] s3_base;
   logic signed [tfcm_pkg::HUES_W-1:0] s3_sum;
   logic signed [tfcm_pkg::HUES_W-1:0] s3_lo;
   logic signed [tfcm_pkg::HUES_W-1:0] s3_hi;
   logic [tfcm_pkg::HUEV_W-1:0]        s3_hue;
   logic [tfcm_pkg::HUEV_W-1:0]        s3_hue_in;
   logic [tfcm_pkg::HUEV_W-1:0]        s3_hue_ff;

   assign s3_qmag = div_out.ovf ? {tfcm_pkg::Q_W{1'b1}} : div_out.quo;
   assign s3_qs   = div_out.neg ? -$signed({2'b00, s3_qmag}) : $signed({2'b00, s3_qmag});
   assign s3_base = $signed(tfcm_pkg::HUES_W'({hue_low_ff,
                                               {tfcm_pkg::HUE_FRACTION_BITS{1'b0}}}));
   assign s3_lo   = $signed(tfcm_pkg::HUES_W'({hue_lo, {tfcm_pkg::HUE_FRACTION_BITS{1'b0}}}));
   assign s3_hi   = $signed(tfcm_pkg::HUES_W'({hue_hi, {tfcm_pkg::HUE_FRACTION_BITS{1'b0}}}));
   assign s3_sum  = s3_qs + s3_base;

   always_comb begin
      if (bounds_equal) begin
         s3_hue = {hue_high_ff, {tfcm_pkg::HUE_FRACTION_BITS{1'b0}}};
      end else if (s3_sum < s3_lo) begin
         s3_hue = s3_lo[tfcm_pkg::HUEV_W-1:0];
      end else if (s3_sum > s3_hi) begin
         s3_hue = s3_hi[tfcm_pkg::HUEV_W-1:0];
      end else begin
         s3_hue = s3_sum[tfcm_pkg::HUEV_W-1:0];
      end
      // one subtract covers hue registers up to 511
      if (s3_hue >= tfcm_pkg::HUEV_W'(tfcm_pkg::WRAP)) begin
         s3_hue_in = s3_hue - tfcm_pkg::HUEV_W'(tfcm_pkg::WRAP);
      end else begin
         s3_hue_in = s3_hue;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) s3_hue_ff <= s3_hue_in;
   end

   // ------------------------------------------------------------------
   // S4: sextant and remainder within it
   // ------------------------------------------------------------------
   tfcm_pkg::sextant_type        s4_sext_in;
   logic [tfcm_pkg::HUEV_W-1:0]  s4_base;
   logic [tfcm_pkg::HUEV_W-1:0]  s4_diff;
   tfcm_pkg::sextant_type        s4_sext_ff;
   logic [tfcm_pkg::SPAN_W-1:0]  s4_rem_ff;

   always_comb begin
      s4_sext_in = tfcm_pkg::SEXT_R_Y;
      s4_base    = '0;
      for (int k = 1; k < 6; k++) begin
         if (s3_hue_ff >= tfcm_pkg::HUEV_W'(tfcm_pkg::SPAN * k)) begin
            s4_sext_in = tfcm_pkg::sextant_type'(3'(k));
            s4_base    = tfcm_pkg::HUEV_W'(tfcm_pkg::SPAN * k);
         end
      end
      s4_diff = s3_hue_ff - s4_base;
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_sext_ff <= s4_sext_in;
         s4_rem_ff  <= s4_diff[tfcm_pkg::SPAN_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // S5: f = rem * 256 / span, restoring against span shifted
   // ------------------------------------------------------------------
   logic [tfcm_pkg::FX_W-1:0]   s5_acc;
   logic [tfcm_pkg::FX_W-1:0]   s5_thr;
   logic [tfcm_pkg::FRAC_W-1:0] s5_f_in;
   logic [tfcm_pkg::FRAC_W-1:0] s5_f_ff;
   tfcm_pkg::sextant_type       s5_sext_ff;

   always_comb begin
      s5_acc  = {s4_rem_ff, {tfcm_pkg::FRAC_W{1'b0}}};
      s5_f_in = '0;
      s5_thr  = '0;
      for (int i = tfcm_pkg::FRAC_W - 1; i >= 0; i--) begin
         s5_thr = tfcm_pkg::FX_W'(tfcm_pkg::SPAN) << i;
         if (s5_acc >= s5_thr) begin
            s5_acc     = s5_acc - s5_thr;
            s5_f_in[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         s5_f_ff    <= s5_f_in;
         s5_sext_ff <= s4_sext_ff;
      end
   end

   // ------------------------------------------------------------------
   // S6: s*f, s*(1-f) and the minimum level m
   // ------------------------------------------------------------------
   logic [tfcm_pkg::LVL_W-1:0]  s6_one_minus_f;
   logic [tfcm_pkg::LVL_W-1:0]  s6_one_minus_s;
   logic [tfcm_pkg::MIX_W-1:0]  s6_m_prod;
   logic [tfcm_pkg::MIX_W-1:0]  s6_sf_ff;
   logic [tfcm_pkg::MIX_W-1:0]  s6_sfc_ff;
   logic [tfcm_pkg::LVL_W-1:0]  s6_m_ff;
   tfcm_pkg::sextant_type       s6_sext_ff;

   assign s6_one_minus_f = tfcm_pkg::LVL_W'(tfcm_pkg::LVL_FULL) - tfcm_pkg::LVL_W'(s5_f_ff);
   assign s6_one_minus_s = tfcm_pkg::LVL_W'(tfcm_pkg::LVL_FULL) - sat_eff;
   assign s6_m_prod = tfcm_pkg::MIX_W'(val_eff) * tfcm_pkg::MIX_W'(s6_one_minus_s);

   always_ff @(posedge clock) begin
      if (s6_ready) begin
         s6_sf_ff   <= tfcm_pkg::MIX_W'(sat_eff) * tfcm_pkg::MIX_W'(s5_f_ff);
         s6_sfc_ff  <= tfcm_pkg::MIX_W'(sat_eff) * tfcm_pkg::MIX_W'(s6_one_minus_f);
         s6_m_ff    <= s6_m_prod[tfcm_pkg::FRAC_W +: tfcm_pkg::LVL_W];
         s6_sext_ff <= s5_sext_ff;
      end
   end

   // ------------------------------------------------------------------
   // S7: falling and rising levels, sextant select, scale to bytes
   // ------------------------------------------------------------------
   localparam int ONE_SQ = 1 << (2 * tfcm_pkg::FRAC_W);

   logic [tfcm_pkg::MV_W-1:0]  s7_n_prod;
   logic [tfcm_pkg::MV_W-1:0]  s7_k_prod;
   logic [tfcm_pkg::LVL_W-1:0] s7_n;
   logic [tfcm_pkg::LVL_W-1:0] s7_k;
   logic [tfcm_pkg::LVL_W-1:0] s7_r;
   logic [tfcm_pkg::LVL_W-1:0] s7_g;
   logic [tfcm_pkg::LVL_W-1:0] s7_b;

   function automatic logic [tfcm_pkg::RGB_W-1:0] to_byte(
      input logic [tfcm_pkg::LVL_W-1:0] c
   );
      logic [tfcm_pkg::MIX_W-1:0] w;
      // c * 255 / 256, truncated
      w = {c, {tfcm_pkg::FRAC_W{1'b0}}} - tfcm_pkg::MIX_W'(c);
      return w[tfcm_pkg::FRAC_W +: tfcm_pkg::RGB_W];
   endfunction

   assign s7_n_prod = tfcm_pkg::MV_W'(val_eff)
                    * tfcm_pkg::MV_W'(tfcm_pkg::MIX_W'(ONE_SQ) - s6_sf_ff);
   assign s7_k_prod = tfcm_pkg::MV_W'(val_eff)
                    * tfcm_pkg::MV_W'(tfcm_pkg::MIX_W'(ONE_SQ) - s6_sfc_ff);
   assign s7_n = s7_n_prod[2 * tfcm_pkg::FRAC_W +: tfcm_pkg::LVL_W];
   assign s7_k = s7_k_prod[2 * tfcm_pkg::FRAC_W +: tfcm_pkg::LVL_W];

   always_comb begin
      case (s6_sext_ff)
         tfcm_pkg::SEXT_R_Y: begin s7_r = val_eff; s7_g = s7_k;    s7_b = s6_m_ff; end
         tfcm_pkg::SEXT_Y_G: begin s7_r = s7_n;    s7_g = val_eff; s7_b = s6_m_ff; end
         tfcm_pkg::SEXT_G_C: begin s7_r = s6_m_ff; s7_g = val_eff; s7_b = s7_k;    end
         tfcm_pkg::SEXT_C_B: begin s7_r = s6_m_ff; s7_g = s7_n;    s7_b = val_eff; end
         tfcm_pkg::SEXT_B_M: begin s7_r = s7_k;    s7_g = s6_m_ff; s7_b = val_eff; end
         default:            begin s7_r = val_eff; s7_g = s6_m_ff; s7_b = s7_n;    end
      endcase
      // no saturation: grey at the brightness level
      if (sat_eff == '0) begin
         s7_r = val_eff;
         s7_g = val_eff;
         s7_b = val_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (s7_ready) begin
         rsp_red   <= to_byte(s7_r);
         rsp_green <= to_byte(s7_g);
         rsp_blue  <= to_byte(s7_b);
      end
   end

`ifndef SYNTH
   // the hue word after the wrap always lies below 360 degrees
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_hue_ff < tfcm_pkg::HUEV_W'(tfcm_pkg::WRAP)))
      else $error("hue word not wrapped below 360");

   // input can only back up when every stage is full and the output is held
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while pipeline can advance");

   // a free output lets the whole pipeline advance
   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled with output free");

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

>>> tb/temperature_false_color_mapper_core_tb.sv
// Self-checking bench for temperature_false_color_mapper_core: predicts each color and compares.
// Depends on tfcm_pkg and the core RTL; drives req, rsp and the APB-style register port.
`timescale 1ns / 1ps

module temperature_false_color_mapper_core_tb;
   import tfcm_pkg::*;

   // Register slots past the end of the list; writes there must be dropped
   localparam int unsigned CSR_SPARE_6 = 6;
   localparam int unsigned CSR_SPARE_7 = 7;

   localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer on either channel
   localparam int HOLD_CYCLES  = 80;     // long receiver hold-off, well past pipeline depth
   localparam int TAIL_CYCLES  = 40;     // settle time after the final drain, before the last check
   localparam int NUM_SETTINGS = 8;
   localparam int ITEMS_PER_SETTING = 100;

   typedef struct packed {
      logic [RGB_W-1:0] red;
      logic [RGB_W-1:0] green;
      logic [RGB_W-1:0] blue;
   } color_t;

   // Holds a private copy of the registers, computes the color of each accepted
   // sample and keeps the colors still owed by the block in arrival order.
   class color_checker;
      logic [TEMP_W-1:0] temp_low;
      logic [TEMP_W-1:0] temp_high;
      logic [HUE_W-1:0]  hue_low;
      logic [HUE_W-1:0]  hue_high;
      logic [LVL_W-1:0]  saturation;
      logic [LVL_W-1:0]  brightness;
      color_t pending_colors[$];
      int errors;
      int checked;

      function new();
         temp_low   = TEMP_LOW_RST;
         temp_high  = TEMP_HIGH_RST;
         hue_low    = HUE_LOW_RST;
         hue_high   = HUE_HIGH_RST;
         saturation = SATURATION_RST;
         brightness = BRIGHTNESS_RST;
         errors     = 0;
         checked    = 0;
      endfunction

      function void report(string msg);
         $display("%0t: mismatch: %s", $time, msg);
         errors++;
      endfunction

      function int pending();
         return pending_colors.size();
      endfunction

      function void load_reg(int unsigned idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TEMP_LOW:   temp_low   = data[TEMP_W-1:0];
            CSR_TEMP_HIGH:  temp_high  = data[TEMP_W-1:0];
            CSR_HUE_LOW:    hue_low    = data[HUE_W-1:0];
            CSR_HUE_HIGH:   hue_high   = data[HUE_W-1:0];
            CSR_SATURATION: saturation = data[LVL_W-1:0];
            CSR_BRIGHTNESS: brightness = data[LVL_W-1:0];
            default: ;
         endcase
      endfunction

      function color_t map_color(logic [TEMP_W-1:0] sample);
         longint one, span, t, tl, th, hl, hh, lo, hi, hue;
         longint s, v, sext, rem, f, m, n, k, r, g, b;
         color_t c;
         one  = longint'(1) << HUE_FRACTION_BITS;
         span = 60 * one;
         t    = longint'($signed(sample));
         tl   = longint'($signed(temp_low));
         th   = longint'($signed(temp_high));
         hl   = longint'(hue_low);
         hh   = longint'(hue_high);
         s    = (saturation > LVL_FULL) ? LVL_FULL : longint'(saturation);
         v    = (brightness > LVL_FULL) ? LVL_FULL : longint'(brightness);

         // Linear map, truncated toward zero, then clamp to the hue span
         if (th == tl) begin
            hue = hh * one;
         end else begin
            lo  = (hl < hh) ? hl : hh;
            hi  = (hl < hh) ? hh : hl;
            hue = (t - tl) * (hh - hl) * one / (th - tl) + hl * one;
            if (hue < lo * one) hue = lo * one;
            if (hue > hi * one) hue = hi * one;
         end

         if (s == 0) begin
            r = v;
            g = v;
            b = v;
         end else begin
            // Wrap once at a full turn, then split into sextant and fraction
            if (hue >= 360 * one) hue = hue - 360 * one;
            sext = hue / span;
            rem  = hue % span;
            f    = (rem << 8) / span;
            m    = (v * (256 - s)) >> 8;
            n    = (v * (65536 - s * f)) >> 16;
            k    = (v * (65536 - s * (256 - f))) >> 16;
            case (sext)
               SEXT_R_Y: begin r = v; g = k; b = m; end
               SEXT_Y_G: begin r = n; g = v; b = m; end
               SEXT_G_C: begin r = m; g = v; b = k; end
               SEXT_C_B: begin r = m; g = n; b = v; end
               SEXT_B_M: begin r = k; g = m; b = v; end
               default:  begin r = v; g = m; b = n; end
            endcase
         end

         c.red   = RGB_W'((r * 255) >> 8);
         c.green = RGB_W'((g * 255) >> 8);
         c.blue  = RGB_W'((b * 255) >> 8);
         return c;
      endfunction

      function void note_sample(logic [TEMP_W-1:0] sample);
         pending_colors.push_back(map_color(sample));
      endfunction

      function void check_color(logic [RGB_W-1:0] red, logic [RGB_W-1:0] green,
                                logic [RGB_W-1:0] blue);
         color_t want;
         if (pending_colors.size() == 0) begin
            report($sformatf("color %0d/%0d/%0d with no sample pending", red, green, blue));
            return;
         end
         want = pending_colors.pop_front();
         checked++;
         if (red !== want.red)
            report($sformatf("red got %0d want %0d", red, want.red));
         if (green !== want.green)
            report($sformatf("green got %0d want %0d", green, want.green));
         if (blue !== want.blue)
            report($sformatf("blue got %0d want %0d", blue, want.blue));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [TEMP_W-1:0]     req_temperature;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [RGB_W-1:0]      rsp_red;
   logic [RGB_W-1:0]      rsp_green;
   logic [RGB_W-1:0]      rsp_blue;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   color_checker board = new();

   int send_gap_pct   = 18;   // chance per draw, drawn again after each idle, that the sender idles before offering
   int recv_stall_pct = 58;   // chance per cycle that the receiver stalls
   bit hold_request   = 0;    // raised once to ask the receiver for a long hold-off
   int quiet_cycles   = 0;
   int samples_sent   = 0;
   int settings_used  = 0;

   temperature_false_color_mapper_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_temperature (req_temperature),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Monitor: note each req transfer, check each rsp transfer, and end the run
   // if neither channel moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_sample(req_temperature);
         if (rsp_valid && !rsp_stall) board.check_color(rsp_red, rsp_green, rsp_blue);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d colors outstanding",
                     QUIET_LIMIT, board.pending());
            $display("temperature_false_color_mapper_core_tb: errors");
            $finish;
         end
      end
   end

   // Receiver: stall at random, or hold off for a long stretch when asked so the
   // pipeline fills and pushes back on req.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Offer one sample; hold it until the block takes the transfer. Call at a
   // falling edge, returns at a falling edge with valid still high.
   task automatic push_sample(input logic [TEMP_W-1:0] sample);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid       = 1;
      req_temperature = sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      samples_sent++;
   endtask

   // Two-phase register write; the checker's copy follows at the write edge.
   task automatic write_csr(input int unsigned idx, input logic [CSR_DATA_W-1:0] data);
      psel    = 1;
      penable = 0;
      pwrite  = 1;
      paddr   = CSR_ADDR_W'(idx << 2);
      pwdata  = data;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.load_reg(idx, data);
      @(negedge clock);
      psel    = 0;
      penable = 0;
      pwrite  = 0;
   endtask

   // Drop valid and wait until every owed color has come back.
   task automatic drain();
      req_valid = 0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Half the samples anywhere in the 16-bit range, half around the mapped span.
   function automatic logic [TEMP_W-1:0] pick_temperature();
      int a, b, lo_t, hi_t;
      if ($urandom_range(1) == 1) return TEMP_W'($urandom());
      a    = $signed(board.temp_low);
      b    = $signed(board.temp_high);
      lo_t = (a < b) ? a : b;
      hi_t = (a < b) ? b : a;
      return TEMP_W'(lo_t - 8 + int'($urandom_range(hi_t - lo_t + 16)));
   endfunction

   task automatic apply_setting(input int which);
      logic [TEMP_W-1:0] pinned;
      pinned = TEMP_W'($urandom());
      case (which)
         0: begin
            // widest temperature span onto the full hue circle
            write_csr(CSR_TEMP_LOW, 32'h0000_8000);
            write_csr(CSR_TEMP_HIGH, 32'h0000_7fff);
            write_csr(CSR_HUE_LOW, 0);
            write_csr(CSR_HUE_HIGH, 360);
            write_csr(CSR_SATURATION, LVL_FULL);
            write_csr(CSR_BRIGHTNESS, LVL_FULL);
         end
         1: begin
            // both ranges reversed
            write_csr(CSR_TEMP_LOW, 32'h0000_7fff);
            write_csr(CSR_TEMP_HIGH, 32'h0000_8000);
            write_csr(CSR_HUE_LOW, 360);
            write_csr(CSR_HUE_HIGH, 0);
            write_csr(CSR_SATURATION, 128);
            write_csr(CSR_BRIGHTNESS, 200);
         end
         2: begin
            // equal bounds, grey, brightness past full
            write_csr(CSR_TEMP_LOW, pinned);
            write_csr(CSR_TEMP_HIGH, pinned);
            write_csr(CSR_HUE_HIGH, $urandom_range(511));
            write_csr(CSR_SATURATION, 0);
            write_csr(CSR_BRIGHTNESS, 511);
         end
         3: begin
            // hue registers past a full turn, saturation past full
            write_csr(CSR_TEMP_LOW, 0);
            write_csr(CSR_TEMP_HIGH, 1600);
            write_csr(CSR_HUE_LOW, $urandom_range(511, 361));
            write_csr(CSR_HUE_HIGH, 511);
            write_csr(CSR_SATURATION, 300);
            write_csr(CSR_BRIGHTNESS, 511);
         end
         4: begin
            // one-step span so nearly every sample clamps; spare slots must be ignored
            write_csr(CSR_SPARE_6, $urandom());
            write_csr(CSR_SPARE_7, $urandom());
            write_csr(CSR_TEMP_LOW, 100);
            write_csr(CSR_TEMP_HIGH, 101);
            write_csr(CSR_HUE_LOW, 0);
            write_csr(CSR_HUE_HIGH, 511);
            write_csr(CSR_SATURATION, 1);
            write_csr(CSR_BRIGHTNESS, 0);
         end
         default: begin
            // anything goes, upper data bits included
            write_csr(CSR_TEMP_LOW, $urandom());
            write_csr(CSR_TEMP_HIGH, $urandom());
            write_csr(CSR_HUE_LOW, $urandom());
            write_csr(CSR_HUE_HIGH, $urandom());
            write_csr(CSR_SATURATION, $urandom());
            write_csr(CSR_BRIGHTNESS, $urandom());
         end
      endcase
      settings_used++;
   endtask

   initial begin : stimulus
      int s;
      int i;
      reset           = 1;
      req_valid       = 0;
      req_temperature = '0;
      psel            = 0;
      penable         = 0;
      pwrite          = 0;
      paddr           = '0;
      pwdata          = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Reset registers: field extremes, both bounds and just past them,
      // and points spread over the cyan-to-red half of the circle.
      push_sample(16'h8000);
      push_sample(16'h7fff);
      push_sample(16'h0000);
      push_sample(16'hffff);
      push_sample(TEMP_W'(320));
      push_sample(TEMP_W'(319));
      push_sample(TEMP_W'(3200));
      push_sample(TEMP_W'(3201));
      push_sample(TEMP_W'(1280));
      push_sample(TEMP_W'(1760));
      push_sample(TEMP_W'(2240));
      push_sample(TEMP_W'(2720));
      settings_used = 1;

      for (s = 0; s < NUM_SETTINGS; s++) begin
         drain();
         // sender eager / receiver busy, then swap, then no idling at all
         if (s < 3) begin
            send_gap_pct   = 18;
            recv_stall_pct = 58;
         end else if (s < 6) begin
            send_gap_pct   = 58;
            recv_stall_pct = 18;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         apply_setting(s);
         if (s == 0) begin
            // sweep the full circle so every sextant and its borders show up
            for (i = 0; i < 12; i++) push_sample(TEMP_W'(-32768 + i * 5461));
            push_sample(16'h7fff);
         end
         if (s == 1) hold_request = 1;
         for (i = 0; i < ITEMS_PER_SETTING; i++) push_sample(pick_temperature());
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.report($sformatf("%0d colors never arrived", board.pending()));

      $display("covered %0d samples over %0d register settings (wrap, grey, equal bounds,",
               samples_sent, settings_used);
      $display("  clamping, reversed ranges, spare slots, long hold-off); %0d colors checked",
               board.checked);
      if (board.errors == 0) begin
         $display("temperature_false_color_mapper_core_tb: clean");
      end else begin
         $display("temperature_false_color_mapper_core_tb: errors");
      end
      $finish;
   end

endmodule
